// File: hdl/salc_pkg.sv
// shared constants, types and helpers for the set-associative lru cache model
package salc_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int ROWS         = 1 << MAX_SET_BITS;
    localparam int WAY_W        = $clog2(MAX_WAYS);

    localparam int SETB_CFG_W   = 4;
    localparam int WAYS_CFG_W   = 4;
    localparam int OFF_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    localparam int KIND_W       = 2;
    localparam int ADDR_W       = 64;
    localparam int TAG_W        = 64;
    localparam int STAMP_W      = 32;
    localparam int CNT_W        = 32;
    localparam int OUTCOME_W    = 2;

    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = 1;
    localparam int Q_CNT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic               is_modify;
        logic [TAG_W-1:0]   block;
        logic [SET_W-1:0]   set_no;
    } req_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]     tag;
        logic [MAX_WAYS-1:0][STAMP_W-1:0]   stamp;
    } row_t;

    typedef struct packed {
        logic               cand;
        logic [STAMP_W-1:0] age;
        logic [WAY_W-1:0]   way;
    } lru_node_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: hdl/salc_req_if.sv
// access request channel
interface salc_req_if import salc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

// File: hdl/salc_rsp_if.sv
// access result channel
interface salc_rsp_if import salc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUTCOME_W-1:0]   first_outcome;
    logic                   second_hit;
    logic [CNT_W-1:0]       hit_total;
    logic [CNT_W-1:0]       miss_total;
    logic [CNT_W-1:0]       eviction_total;

    modport source (output valid, output first_outcome, output second_hit,
                    output hit_total, output miss_total, output eviction_total,
                    input ready);
    modport sink   (input valid, input first_outcome, input second_hit,
                    input hit_total, input miss_total, input eviction_total,
                    output ready);
endinterface

// File: hdl/set_assoc_lru_cache_sim_unit.sv
// top level of the set-associative lru cache model
//
// req carries one access (kind, address); a transfer takes place when valid
// and ready are both high. rsp returns one result per access: outcome of the
// first lookup, whether a modify's second lookup hit, and the running
// saturating hit, miss and eviction totals.
// cfg_we/cfg_index/cfg_data write set_index_bits (0), ways_in_use (1) and
// offset_bits (2); write only while no access is in flight.
// a result passes through the queue, the row register, the compare registers
// and the result register. the back end takes one access at a time through the
// read, compare and select-and-write-back of one set row, then takes the next.
// a two-entry queue lets the front keep taking requests while the back end
// works or waits; a stalled rsp holds its result and the back end holds the
// next access in its final step until the result register frees.
// after reset the set memory is cleared one set per cycle, all 256 sets, with
// req.ready low; configuration writes are taken during that time.
module set_assoc_lru_cache_sim_unit import salc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    salc_req_if.sink                req,
    salc_rsp_if.source              rsp
);

    logic                   push_valid;
    logic                   push_ready;
    req_t                   push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    req_t                   pop_data;
    logic [WAYS_CFG_W-1:0]  ways_eff;
    logic                   clearing;

    salc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .ways_eff   (ways_eff)
    );

    salc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    salc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .ways_eff   (ways_eff),
        .clearing   (clearing),
        .rsp        (rsp)
    );

endmodule

// File: hdl/salc_front.sv
// front end: configuration registers, request intake and set/block split
module salc_front import salc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    salc_req_if.sink                req,
    input  logic                    clearing,
    output logic                    push_valid,
    input  logic                    push_ready,
    output req_t                    push_data,
    output logic [WAYS_CFG_W-1:0]   ways_eff
);

    logic [SETB_CFG_W-1:0] set_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_reg;
    logic [OFF_W-1:0]      offset_reg;

    logic [SETB_CFG_W-1:0] set_bits_eff;
    logic [SET_W:0]        set_onehot;
    logic [SET_W-1:0]      set_mask;
    logic [TAG_W-1:0]      block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= '0;
            ways_reg     <= WAYS_CFG_W'(1);
            offset_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS: set_bits_reg <= cfg_data[SETB_CFG_W-1:0];
                CFG_WAYS:     ways_reg     <= cfg_data[WAYS_CFG_W-1:0];
                CFG_OFFSET:   offset_reg   <= cfg_data[OFF_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        set_bits_eff = (set_bits_reg > SETB_CFG_W'(MAX_SET_BITS))
                       ? SETB_CFG_W'(MAX_SET_BITS) : set_bits_reg;
        set_onehot   = (SET_W+1)'(1) << set_bits_eff;
        set_mask     = set_onehot[SET_W-1:0] - SET_W'(1);
        block        = req.address >> offset_reg;

        if (ways_reg == '0)
            ways_eff = WAYS_CFG_W'(1);
        else if (ways_reg > WAYS_CFG_W'(MAX_WAYS))
            ways_eff = WAYS_CFG_W'(MAX_WAYS);
        else
            ways_eff = ways_reg;

        push_data.is_modify = (req.kind == KIND_MODIFY);
        push_data.block     = block;
        push_data.set_no    = block[SET_W-1:0] & set_mask;
    end

    assign push_valid = req.valid && !clearing;
    assign req.ready  = push_ready && !clearing;

endmodule

// File: hdl/salc_queue.sv
// two-entry request queue between front and back
module salc_queue import salc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  req_t    push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output req_t    pop_data
);

    req_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hdl/salc_back.sv
// back end: set memory, tag compare, lru choice, counters and result register
module salc_back import salc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  req_t                    pop_data,
    input  logic [WAYS_CFG_W-1:0]   ways_eff,
    output logic                    clearing,
    salc_rsp_if.source              rsp
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_SEL   = 2'd3;

    row_t mem [ROWS];

    logic [1:0]             state_reg, state_next;
    logic [SET_W-1:0]       clr_addr_reg;
    req_t                   req_reg;
    row_t                   row_reg;
    logic [STAMP_W-1:0]     clock_reg, clock_next;
    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]       evict_cnt_reg, evict_cnt_next;

    logic                   hit_any_reg, hit_any_next;
    logic [WAY_W-1:0]       hit_way_reg, hit_way_next;
    logic                   free_any_reg, free_any_next;
    logic [WAY_W-1:0]       free_way_reg, free_way_next;
    logic [MAX_WAYS-1:0]    cand_reg, cand_next;
    logic [STAMP_W-1:0]     age_reg [MAX_WAYS];
    logic [STAMP_W-1:0]     age_next [MAX_WAYS];

    logic                   rsp_valid_reg;
    logic [OUTCOME_W-1:0]   outcome_reg, outcome_next;
    logic                   second_hit_reg;

    lru_node_t              node [2*MAX_WAYS];
    logic [WAY_W-1:0]       victim_way;
    logic [WAY_W-1:0]       way_sel;
    row_t                   row_new;
    logic                   commit;
    logic                   do_read;
    logic                   mem_we;
    logic [SET_W-1:0]       mem_waddr;
    row_t                   mem_wdata;
    logic [STAMP_W-1:0]     clock_hit;

    assign clearing  = (state_reg == ST_CLEAR);
    assign pop_ready = (state_reg == ST_IDLE);
    assign do_read   = pop_valid && pop_ready;
    assign commit    = (state_reg == ST_SEL) && (!rsp_valid_reg || rsp.ready);

    // tag compare, free search and ages over the ways in use
    always_comb
    begin
        hit_any_next  = 1'b0;
        hit_way_next  = '0;
        free_any_next = 1'b0;
        free_way_next = '0;
        clock_hit     = clock_reg + STAMP_W'(1);
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            cand_next[w] = row_reg.valid[w] && (WAYS_CFG_W'(w) < ways_eff);
            age_next[w]  = clock_hit - row_reg.stamp[w];
            if (cand_next[w] && (row_reg.tag[w] == req_reg.block))
            begin
                hit_any_next = 1'b1;
                hit_way_next = WAY_W'(w);
            end
            if (!row_reg.valid[w] && (WAYS_CFG_W'(w) < ways_eff))
            begin
                free_any_next = 1'b1;
                free_way_next = WAY_W'(w);
            end
        end
    end

    // oldest-line tree, lower way wins a tie
    always_comb
    begin
        node[0] = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            node[MAX_WAYS + w].cand = cand_reg[w];
            node[MAX_WAYS + w].age  = age_reg[w];
            node[MAX_WAYS + w].way  = WAY_W'(w);
        end
        for (int i = MAX_WAYS - 1; i >= 1; i--)
        begin
            if (node[2*i].cand && (!node[2*i+1].cand || node[2*i].age >= node[2*i+1].age))
                node[i] = node[2*i];
            else
                node[i] = node[2*i+1];
        end
        victim_way = node[1].way;
    end

    always_comb
    begin
        if (hit_any_reg)
        begin
            way_sel      = hit_way_reg;
            outcome_next = OUT_HIT;
        end
        else if (free_any_reg)
        begin
            way_sel      = free_way_reg;
            outcome_next = OUT_FILL;
        end
        else
        begin
            way_sel      = victim_way;
            outcome_next = OUT_EVICT;
        end

        clock_next = clock_reg + (req_reg.is_modify ? STAMP_W'(2) : STAMP_W'(1));

        row_new                = row_reg;
        row_new.valid[way_sel] = 1'b1;
        row_new.tag[way_sel]   = req_reg.block;
        row_new.stamp[way_sel] = clock_next;

        hit_cnt_next   = hit_any_reg ? sat_inc(hit_cnt_reg) : hit_cnt_reg;
        if (req_reg.is_modify)
            hit_cnt_next = sat_inc(hit_cnt_next);
        miss_cnt_next  = hit_any_reg ? miss_cnt_reg : sat_inc(miss_cnt_reg);
        evict_cnt_next = (outcome_next == OUT_EVICT) ? sat_inc(evict_cnt_reg)
                                                     : evict_cnt_reg;

        mem_we    = clearing || commit;
        mem_waddr = clearing ? clr_addr_reg : req_reg.set_no;
        mem_wdata = clearing ? row_t'('0) : row_new;
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR: state_next = (clr_addr_reg == SET_W'(ROWS - 1)) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:  state_next = do_read ? ST_CMP : ST_IDLE;
            ST_CMP:   state_next = ST_SEL;
            ST_SEL:   state_next = commit ? ST_IDLE : ST_SEL;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clock_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_addr_reg <= clr_addr_reg + SET_W'(1);
            if (commit)
            begin
                clock_reg     <= clock_next;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
            req_reg <= pop_data;
        if (state_reg == ST_CMP)
        begin
            hit_any_reg  <= hit_any_next;
            hit_way_reg  <= hit_way_next;
            free_any_reg <= free_any_next;
            free_way_reg <= free_way_next;
            cand_reg     <= cand_next;
            age_reg      <= age_next;
        end
        if (commit)
        begin
            outcome_reg    <= outcome_next;
            second_hit_reg <= req_reg.is_modify;
        end
    end

    // set memory: one row of all ways per set
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (do_read)
            row_reg <= mem[pop_data.set_no];
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.first_outcome  = outcome_reg;
    assign rsp.second_hit     = second_hit_reg;
    assign rsp.hit_total      = hit_cnt_reg;
    assign rsp.miss_total     = miss_cnt_reg;
    assign rsp.eviction_total = evict_cnt_reg;

endmodule

// File: hdl/salc_checker.sv
// port-level checks for the cache model, bound to the top level
module salc_checker import salc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rsp_valid,
    input  logic                    rsp_ready,
    input  logic [OUTCOME_W-1:0]    first_outcome,
    input  logic                    second_hit,
    input  logic [CNT_W-1:0]        hit_total,
    input  logic [CNT_W-1:0]        miss_total,
    input  logic [CNT_W-1:0]        eviction_total
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped before transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(first_outcome) && $stable(second_hit)
                                    && $stable(hit_total) && $stable(miss_total)
                                    && $stable(eviction_total))
        else $error("rsp payload changed while stalled");

    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> eviction_total <= miss_total)
        else $error("more evictions than misses");

    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (first_outcome == OUT_FILL || first_outcome == OUT_EVICT)
        |-> miss_total != '0)
        else $error("miss reported with zero miss total");

    a_second_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && second_hit |-> hit_total != '0)
        else $error("second hit reported with zero hit total");

endmodule

bind set_assoc_lru_cache_sim_unit salc_checker u_salc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .first_outcome  (rsp.first_outcome),
    .second_hit     (rsp.second_hit),
    .hit_total      (rsp.hit_total),
    .miss_total     (rsp.miss_total),
    .eviction_total (rsp.eviction_total)
);

// File: bench/salc_access_checker.sv
`timescale 1ns / 1ps
// access checker: tracks the cache state, predicts each result and compares the result channel
module salc_access_checker import salc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    salc_req_if                     req,
    salc_rsp_if                     rsp,
    output int                      fail_count,
    output int                      outstanding
);

    localparam int LINES = ROWS * MAX_WAYS;

    typedef struct packed {
        logic [OUTCOME_W-1:0]   first_outcome;
        logic                   second_hit;
        logic [CNT_W-1:0]       hit_total;
        logic [CNT_W-1:0]       miss_total;
        logic [CNT_W-1:0]       eviction_total;
    } access_result_t;

    logic [SETB_CFG_W-1:0]  set_bits_cfg;
    logic [WAYS_CFG_W-1:0]  ways_cfg;
    logic [OFF_W-1:0]       offset_cfg;

    bit                     held [LINES];
    logic [TAG_W-1:0]       held_block [LINES];
    logic [STAMP_W-1:0]     last_use [LINES];
    logic [STAMP_W-1:0]     use_clock;
    logic [CNT_W-1:0]       hits;
    logic [CNT_W-1:0]       misses;
    logic [CNT_W-1:0]       evictions;

    access_result_t         expected_results [$];
    int                     errors = 0;
    int                     pending_n = 0;

    assign fail_count  = errors;
    assign outstanding = pending_n;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // one lookup with fill or lru eviction on a miss
    function automatic logic [OUTCOME_W-1:0] cache_lookup(input logic [ADDR_W-1:0] address);
        int unsigned        sb;
        int unsigned        nw;
        int unsigned        base;
        int unsigned        free_way;
        int unsigned        victim;
        int unsigned        slot;
        bit                 have_free;
        bit                 have_victim;
        logic [TAG_W-1:0]   block;
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] oldest;
        sb = (set_bits_cfg > SETB_CFG_W'(MAX_SET_BITS)) ? 32'(MAX_SET_BITS)
                                                         : 32'(set_bits_cfg);
        if (ways_cfg == '0)
            nw = 32'(1);
        else if (ways_cfg > WAYS_CFG_W'(MAX_WAYS))
            nw = 32'(MAX_WAYS);
        else
            nw = 32'(ways_cfg);
        block = address >> offset_cfg;
        base = int'(block & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
        use_clock = use_clock + STAMP_W'(1);
        have_free = 1'b0;
        have_victim = 1'b0;
        free_way = 0;
        victim = 0;
        oldest = '0;
        for (int w = 0; w < nw; w++)
        begin
            if (held[base + w])
            begin
                if (held_block[base + w] == block)
                begin
                    last_use[base + w] = use_clock;
                    hits = count_up(hits);
                    return OUT_HIT;
                end
                age = use_clock - last_use[base + w];
                if (!have_victim || age > oldest)
                begin
                    oldest = age;
                    victim = w;
                    have_victim = 1'b1;
                end
            end
            else if (!have_free)
            begin
                free_way = w;
                have_free = 1'b1;
            end
        end
        misses = count_up(misses);
        slot = base + (have_free ? free_way : victim);
        held[slot] = 1'b1;
        held_block[slot] = block;
        last_use[slot] = use_clock;
        if (have_free)
            return OUT_FILL;
        evictions = count_up(evictions);
        return OUT_EVICT;
    endfunction

    function automatic access_result_t predict_access(input logic [KIND_W-1:0] kind,
                                                      input logic [ADDR_W-1:0] address);
        access_result_t r;
        r.first_outcome = cache_lookup(address);
        r.second_hit = 1'b0;
        if (kind == KIND_MODIFY)
            r.second_hit = (cache_lookup(address) == OUT_HIT);
        r.hit_total = hits;
        r.miss_total = misses;
        r.eviction_total = evictions;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        access_result_t want;
        if (!rst_n)
        begin
            set_bits_cfg = '0;
            ways_cfg = WAYS_CFG_W'(1);
            offset_cfg = '0;
            foreach (held[i])
                held[i] = 1'b0;
            use_clock = '0;
            hits = '0;
            misses = '0;
            evictions = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SET_BITS: set_bits_cfg = cfg_data[SETB_CFG_W-1:0];
                    CFG_WAYS:     ways_cfg = cfg_data[WAYS_CFG_W-1:0];
                    CFG_OFFSET:   offset_cfg = cfg_data[OFF_W-1:0];
                    default:      ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with no access outstanding", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("first_outcome", CNT_W'(want.first_outcome),
                                CNT_W'(rsp.first_outcome));
                    check_field("second_hit", CNT_W'(want.second_hit), CNT_W'(rsp.second_hit));
                    check_field("hit_total", want.hit_total, rsp.hit_total);
                    check_field("miss_total", want.miss_total, rsp.miss_total);
                    check_field("eviction_total", want.eviction_total, rsp.eviction_total);
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(predict_access(req.kind, req.address));
        end
        pending_n = expected_results.size();
    end

endmodule

// File: bench/set_assoc_lru_cache_sim_unit_tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, configuration phases, access stimulus and the verdict
module set_assoc_lru_cache_sim_unit_tb;
    import salc_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [CFG_DATA_W-1:0] SET_BITS_DATA [PHASES] =
        '{6'd0, 6'd8, 6'd63, 6'd9, 6'd2, 6'd1, 6'd4, 6'd3};
    localparam logic [CFG_DATA_W-1:0] WAYS_DATA     [PHASES] =
        '{6'd1, 6'd8, 6'd48, 6'd15, 6'd4, 6'd2, 6'd8, 6'd3};
    localparam logic [CFG_DATA_W-1:0] OFFSET_DATA   [PHASES] =
        '{6'd0, 6'd63, 6'd6, 6'd2, 6'd3, 6'd0, 6'd12, 6'd1};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     outstanding;
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    int                     holds_asked = 0;
    int                     holds_served = 0;
    int                     quiet_cycles = 0;
    logic [OFF_W-1:0]       cur_offset = '0;
    logic [ADDR_W-1:0]      recent_addr [16];

    salc_req_if req ();
    salc_rsp_if rsp ();

    set_assoc_lru_cache_sim_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    salc_access_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, plus one long hold for each phase that asks for one
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] set_bits,
                                input logic [CFG_DATA_W-1:0] ways,
                                input logic [CFG_DATA_W-1:0] offset);
        write_reg(CFG_SET_BITS, set_bits);
        write_reg(CFG_WAYS, ways);
        write_reg(CFG_OFFSET, offset);
        cfg_we <= 1'b0;
        cur_offset = offset;
    endtask

    // one access transfer, with random idle cycles ahead of it
    task automatic send_access(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] address);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.address <= address;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return KIND_LOAD;
        if (r < 60)
            return KIND_STORE;
        if (r < 92)
            return KIND_MODIFY;
        return KIND_SPARE;
    endfunction

    // mostly reused or low block numbers so that sets fill, hit and evict
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned        r;
        logic [ADDR_W-1:0]  low_mask;
        logic [ADDR_W-1:0]  a;
        r = $urandom_range(99);
        low_mask = (64'd1 << cur_offset) - 64'd1;
        if (r < 45)
            a = recent_addr[$urandom_range(15)];
        else if (r < 85)
            a = (64'($urandom_range(95)) << cur_offset) | ({$urandom, $urandom} & low_mask);
        else
            a = {$urandom, $urandom};
        recent_addr[$urandom_range(15)] = a;
        return a;
    endfunction

    initial
    begin
        foreach (recent_addr[i])
            recent_addr[i] = '0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SET_BITS;
        cfg_data <= '0;
        req.valid <= 1'b0;
        req.kind <= KIND_LOAD;
        req.address <= '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // four sets of two ways, 16 byte blocks
        write_reg(CFG_SPARE, '1);
        apply_config(6'd2, 6'd2, 6'd4);
        send_access(KIND_LOAD, 64'h0);
        send_access(KIND_LOAD, 64'hc);
        send_access(KIND_STORE, 64'h10);
        send_access(KIND_MODIFY, 64'h20);
        send_access(KIND_MODIFY, 64'h0);
        send_access(KIND_SPARE, 64'h40);
        send_access(KIND_LOAD, 64'h80);
        send_access(KIND_LOAD, 64'h0);
        send_access(KIND_STORE, 64'h40);
        send_access(KIND_LOAD, 64'hffff_ffff_ffff_ffff);
        send_access(KIND_STORE, 64'h8000_0000_0000_0030);
        send_access(KIND_MODIFY, 64'h7fff_ffff_ffff_fff0);
        send_access(KIND_SPARE, 64'hffff_ffff_ffff_ffff);
        send_access(KIND_LOAD, 64'h8000_0000_0000_0030);
        settle();

        // one way only: lines in the hidden way are kept but not searched
        apply_config(6'd2, 6'd1, 6'd4);
        send_access(KIND_LOAD, 64'h40);
        send_access(KIND_LOAD, 64'h0);
        send_access(KIND_MODIFY, 64'h80);
        settle();
        apply_config(6'd2, 6'd2, 6'd4);
        send_access(KIND_LOAD, 64'h40);
        send_access(KIND_LOAD, 64'h80);
        send_access(KIND_STORE, 64'h0);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_config(SET_BITS_DATA[phase], WAYS_DATA[phase], OFFSET_DATA[phase]);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    holds_asked++;
                end
                1:
                begin
                    send_idle_pct = 71;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_access(pick_kind(), pick_address());
            settle();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
